// File: rtl/core/ihc_pkg.sv
// ----------------------------------------------------------------------------
// ihc_pkg
// Shared types and constants for the open-inode slot table (get/put with
// reference counts): field widths, status codes, control command/status.
// ----------------------------------------------------------------------------
package ihc_pkg;

    // field widths
    localparam int unsigned INODE_W    = 16;
    localparam int unsigned SLOT_IDX_W = 6;
    localparam int unsigned REFS_W     = 8;
    localparam int unsigned BLK_W      = 16;
    localparam int unsigned OFF_W      = 12;

    // inode records per disk block is 2**REC_IDX_W
    localparam int unsigned REC_IDX_W    = 6;
    localparam int unsigned RECORD_BYTES = 64;

    localparam logic [REFS_W-1:0] REF_MAX       = '1;
    localparam logic [BLK_W-1:0]  FIRST_BLK_RST = 16'd3;

    // request type codes
    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    // result status codes
    typedef enum logic [2:0] {
        ST_HIT         = 3'd0,
        ST_LOADED      = 3'd1,
        ST_FULL        = 3'd2,
        ST_OVERFLOW    = 3'd3,
        ST_RELEASED    = 3'd4,
        ST_DECREMENTED = 3'd5,
        ST_IDLE        = 3'd6
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic load_req;  // capture input beat
        logic look;      // register compare vectors and put-slot read
        logic commit;    // update table, load output register
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_busy;  // output register holds a beat that is not taken
    } t_dp_status;

endpackage

// File: rtl/core/ihc_ctrl.sv
// ----------------------------------------------------------------------------
// ihc_ctrl
// Sequencer for the slot table: accept a request, run the compare step,
// then the pick/commit step. A new request is taken in the commit cycle.
// ----------------------------------------------------------------------------
module ihc_ctrl
    import ihc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_sts,
    output t_ctrl_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOOK = 3'b010,
        S_PICK = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   can_commit;
    logic   accept;

    // handshake and commands
    assign can_commit = (r_state == S_PICK) && !i_sts.out_busy;
    assign o_in_stall = !((r_state == S_IDLE) || can_commit);
    assign accept     = i_in_valid && !o_in_stall;

    assign o_cmd.load_req = accept;
    assign o_cmd.look     = (r_state == S_LOOK);
    assign o_cmd.commit   = can_commit;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_LOOK;
            end
            S_LOOK: begin
                n_state = S_PICK;
            end
            S_PICK: begin
                if (can_commit) n_state = accept ? S_LOOK : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // accepted beat always starts the compare step
    a_accept_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_LOOK))
        else $error("accepted request did not enter compare step");

    // compare step is always followed by the pick step
    a_look_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK) |=> (r_state == S_PICK))
        else $error("compare step not followed by pick step");

endmodule

// File: rtl/core/ihc_dp.sv
// ----------------------------------------------------------------------------
// ihc_dp
// Slot table datapath: per-slot inode and count registers, parallel match
// and free vectors, lowest-free pick, count update, block/offset math and
// the output register.
// ----------------------------------------------------------------------------
module ihc_dp
    import ihc_pkg::*;
#(
    parameter int unsigned SLOT_COUNT = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctrl_cmd             i_cmd,
    output t_dp_status            o_sts,
    input  logic                  i_cfg_wr_en,
    input  logic [BLK_W-1:0]      i_cfg_wr_data,
    input  logic                  i_req_type,
    input  logic [INODE_W-1:0]    i_inode_number,
    input  logic [SLOT_IDX_W-1:0] i_slot_index,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [2:0]            o_status,
    output logic [SLOT_IDX_W-1:0] o_result_slot,
    output logic [REFS_W-1:0]     o_ref_after,
    output logic [BLK_W-1:0]      o_disk_block,
    output logic [OFF_W-1:0]      o_byte_offset
);

    localparam int unsigned SW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int unsigned XW  = (SW > SLOT_IDX_W) ? SW : SLOT_IDX_W;
    localparam int unsigned IXW = XW + 1;

    // slot table
    logic [INODE_W-1:0] r_slot_inode [SLOT_COUNT];
    logic [REFS_W-1:0]  r_slot_refs  [SLOT_COUNT];
    logic [BLK_W-1:0]   r_first_blk;

    // captured request
    logic                  r_req_type;
    logic [INODE_W-1:0]    r_ino;
    logic [SLOT_IDX_W-1:0] r_idx;

    // compare-step results
    logic [SLOT_COUNT-1:0] r_hit_vec;
    logic [SLOT_COUNT-1:0] r_free_vec;
    logic [REFS_W-1:0]     r_hit_refs;
    logic [REFS_W-1:0]     r_put_refs;
    logic [INODE_W-1:0]    r_put_inode;
    logic                  r_put_ok;

    // output register
    logic                  r_out_valid;
    t_status               r_out_status;
    logic [SLOT_IDX_W-1:0] r_out_slot;
    logic [REFS_W-1:0]     r_out_refs;
    logic [BLK_W-1:0]      r_out_blk;
    logic [OFF_W-1:0]      r_out_off;

    // combinational
    logic [IXW-1:0]        idx_x;
    logic                  put_in_range;
    logic [SW-1:0]         put_sel;
    logic [SLOT_COUNT-1:0] hit_vec;
    logic [SLOT_COUNT-1:0] free_vec;
    logic [REFS_W-1:0]     hit_refs;
    logic [SLOT_COUNT-1:0] free_iso;
    logic [SW-1:0]         hit_idx;
    logic [SW-1:0]         free_idx;
    logic                  hit_any;
    logic                  free_any;
    logic [REFS_W-1:0]     put_dec;
    logic [INODE_W-1:0]    loc_ino;
    logic [BLK_W-1:0]      loc_blk;
    logic [OFF_W-1:0]      loc_off;
    t_status               n_status;
    logic [SLOT_IDX_W-1:0] n_slot;
    logic [REFS_W-1:0]     n_refs;
    logic                  n_use_loc;
    logic                  wr_en;
    logic                  wr_ino_en;
    logic [SW-1:0]         wr_idx;
    logic [REFS_W-1:0]     wr_refs;

    // put slot range check and select
    assign idx_x        = IXW'(r_idx);
    assign put_in_range = idx_x < IXW'(SLOT_COUNT);
    assign put_sel      = idx_x[SW-1:0];

    // per-slot match and free flags, count of the (single) hit slot
    always_comb begin
        hit_refs = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            free_vec[i] = (r_slot_refs[i] == '0);
            hit_vec[i]  = !free_vec[i] && (r_slot_inode[i] == r_ino);
            hit_refs    = hit_refs | (hit_vec[i] ? r_slot_refs[i] : '0);
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req_type <= i_req_type;
            r_ino      <= i_inode_number;
            r_idx      <= i_slot_index;
        end
    end

    // compare step registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.look) begin
            r_hit_vec   <= hit_vec;
            r_free_vec  <= free_vec;
            r_hit_refs  <= hit_refs;
            r_put_ok    <= put_in_range;
            r_put_refs  <= put_in_range ? r_slot_refs[put_sel] : '0;
            r_put_inode <= r_slot_inode[put_sel];
        end
    end

    // hit index (one-hot) and lowest free slot
    assign free_iso = r_free_vec & (~r_free_vec + SLOT_COUNT'(1));
    assign hit_any  = |r_hit_vec;
    assign free_any = |r_free_vec;

    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (r_hit_vec[i]) hit_idx  = hit_idx | SW'(i);
            if (free_iso[i])  free_idx = free_idx | SW'(i);
        end
    end

    // disk location of an inode record
    assign loc_ino = (r_req_type == REQ_GET) ? r_ino : r_put_inode;
    assign loc_blk = BLK_W'(loc_ino >> REC_IDX_W) + r_first_blk;
    assign loc_off = OFF_W'(32'(loc_ino[REC_IDX_W-1:0]) * RECORD_BYTES);

    assign put_dec = r_put_refs - REFS_W'(1);

    // result and table update
    always_comb begin
        n_status  = ST_IDLE;
        n_slot    = r_idx;
        n_refs    = '0;
        n_use_loc = 1'b0;
        wr_en     = 1'b0;
        wr_ino_en = 1'b0;
        wr_idx    = put_sel;
        wr_refs   = put_dec;
        if (r_req_type == REQ_GET) begin
            priority if (hit_any) begin
                n_slot = SLOT_IDX_W'(XW'(hit_idx));
                wr_idx = hit_idx;
                if (r_hit_refs == REF_MAX) begin
                    n_status = ST_OVERFLOW;
                    n_refs   = REF_MAX;
                end else begin
                    n_status = ST_HIT;
                    n_refs   = r_hit_refs + REFS_W'(1);
                    wr_en    = 1'b1;
                    wr_refs  = n_refs;
                end
            end else if (free_any) begin
                n_status  = ST_LOADED;
                n_slot    = SLOT_IDX_W'(XW'(free_idx));
                n_refs    = REFS_W'(1);
                n_use_loc = 1'b1;
                wr_en     = 1'b1;
                wr_ino_en = 1'b1;
                wr_idx    = free_idx;
                wr_refs   = REFS_W'(1);
            end else begin
                n_status = ST_FULL;
                n_slot   = '0;
            end
        end else if (r_put_ok && (r_put_refs != '0)) begin
            wr_en = 1'b1;
            if (put_dec == '0) begin
                n_status  = ST_RELEASED;
                n_use_loc = 1'b1;
            end else begin
                n_status = ST_DECREMENTED;
                n_refs   = put_dec;
            end
        end
    end

    // reference counts: cleared at reset, all slots free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_slot_refs[i] <= '0;
            end
        end else if (i_cmd.commit && wr_en) begin
            r_slot_refs[wr_idx] <= wr_refs;
        end
    end

    // inode numbers: only read behind a nonzero count
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && wr_ino_en) begin
            r_slot_inode[wr_idx] <= r_ino;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_blk <= FIRST_BLK_RST;
        end else if (i_cfg_wr_en) begin
            r_first_blk <= i_cfg_wr_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_status <= n_status;
            r_out_slot   <= n_slot;
            r_out_refs   <= n_refs;
            r_out_blk    <= n_use_loc ? loc_blk : '0;
            r_out_off    <= n_use_loc ? loc_off : '0;
        end
    end

    assign o_sts.out_busy = r_out_valid && i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_result_slot  = r_out_slot;
    assign o_ref_after    = r_out_refs;
    assign o_disk_block   = r_out_blk;
    assign o_byte_offset  = r_out_off;

    // in-use slots hold distinct inode numbers, so at most one hit
    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> $onehot0(r_hit_vec))
        else $error("more than one in-use slot matched the inode");

    // a committed request always presents a result beat
    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("commit did not load output register");

endmodule

// File: rtl/core/inode_handle_cache_refcount_core.sv
// ----------------------------------------------------------------------------
// inode_handle_cache_refcount_core
// Open-inode slot table with reference counts. Get finds or claims a slot,
// put releases one and reports the writeback location when the count drops
// to zero.
// ----------------------------------------------------------------------------
// Sequence: a request is captured; the compare step registers the match and
// free vectors; the pick step then updates the table and loads the output
// register. A new request is taken only as the previous one commits (or when
// idle), so requests do not overlap; an output stall holds the pick step.
// Reset: all counts cleared (every slot free) at once, first_inode_block
// set to 3; no clearing pass, requests are taken right after reset.
// ----------------------------------------------------------------------------
module inode_handle_cache_refcount_core
    import ihc_pkg::*;
#(
    parameter int unsigned SLOT_COUNT = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [BLK_W-1:0]      i_cfg_wr_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_req_type,
    input  logic [INODE_W-1:0]    i_inode_number,
    input  logic [SLOT_IDX_W-1:0] i_slot_index,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [2:0]            o_status,
    output logic [SLOT_IDX_W-1:0] o_result_slot,
    output logic [REFS_W-1:0]     o_ref_after,
    output logic [BLK_W-1:0]      o_disk_block,
    output logic [OFF_W-1:0]      o_byte_offset
);

    t_ctrl_cmd  cmd;
    t_dp_status sts;

    // sequencer
    ihc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // slot table and result path
    ihc_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_req_type     (i_req_type),
        .i_inode_number (i_inode_number),
        .i_slot_index   (i_slot_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_result_slot  (o_result_slot),
        .o_ref_after    (o_ref_after),
        .o_disk_block   (o_disk_block),
        .o_byte_offset  (o_byte_offset)
    );

endmodule

// File: dv/inode_handle_cache_refcount_core_tb.sv
// ----------------------------------------------------------------------------
// inode_handle_cache_refcount_core_tb
// Self-checking bench for the open-inode slot table. Every accepted request is
// run through a local copy of the slot table (inode numbers, reference counts,
// inode area base) to form the expected result beat. Each result beat from the
// block is checked field by field against the oldest expected beat. Directed
// tests cover every status but full and overflow, and the field extremes. Dedicated tests cover the
// full table, count saturation and output backpressure. Random mixes follow,
// run under several inode area bases and idle patterns.
// ----------------------------------------------------------------------------
module inode_handle_cache_refcount_core_tb;
    import ihc_pkg::*;

    localparam int N_SLOTS      = 64;
    localparam int RECS_PER_BLK = 1 << REC_IDX_W;
    localparam int LONG_HOLD    = 400;   // receiver hold-off, in cycles
    localparam int DRAIN_CYCLES = 4;     // margin after the last result
    localparam int STUCK_LIMIT  = 2000;  // cycles with no beat on either side

    // one result beat
    typedef struct packed {
        t_status               status;
        logic [SLOT_IDX_W-1:0] slot;
        logic [REFS_W-1:0]     refs;
        logic [BLK_W-1:0]      blk;
        logic [OFF_W-1:0]      off;
    } t_slot_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [BLK_W-1:0]      i_cfg_wr_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_req_type;
    logic [INODE_W-1:0]    i_inode_number;
    logic [SLOT_IDX_W-1:0] i_slot_index;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [2:0]            o_status;
    logic [SLOT_IDX_W-1:0] o_result_slot;
    logic [REFS_W-1:0]     o_ref_after;
    logic [BLK_W-1:0]      o_disk_block;
    logic [OFF_W-1:0]      o_byte_offset;

    // local copy of the table and the base register
    logic [INODE_W-1:0] slot_ino  [N_SLOTS];
    logic [REFS_W-1:0]  slot_refs [N_SLOTS];
    logic [BLK_W-1:0]   inode_area_base;

    t_slot_result expected_results[$];
    int           n_errors     = 0;
    int           stuck_cycles = 0;
    bit           tx_idle      = 1'b1;
    bit           rx_idle      = 1'b1;
    bit           rx_long_hold = 1'b0;

    inode_handle_cache_refcount_core #(
        .SLOT_COUNT(N_SLOTS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_inode_number (i_inode_number),
        .i_slot_index   (i_slot_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_result_slot  (o_result_slot),
        .o_ref_after    (o_ref_after),
        .o_disk_block   (o_disk_block),
        .o_byte_offset  (o_byte_offset)
    );

    always #5 i_clk = ~i_clk;

    // block and byte offset of an inode record, under the current base
    function automatic logic [BLK_W+OFF_W-1:0] record_location(input logic [INODE_W-1:0] ino);
        logic [BLK_W-1:0] blk;
        logic [OFF_W-1:0] off;
        blk = BLK_W'(ino / RECS_PER_BLK) + inode_area_base;
        off = OFF_W'((ino % RECS_PER_BLK) * RECORD_BYTES);
        return {blk, off};
    endfunction

    // apply one request to the local table, return the beat it must produce
    function automatic t_slot_result predict_slot_table(input logic rt,
                                                        input logic [INODE_W-1:0] ino,
                                                        input logic [SLOT_IDX_W-1:0] idx);
        t_slot_result res;
        int hit;
        int free_slot;
        res.status = ST_IDLE;
        res.slot   = '0;
        res.refs   = '0;
        res.blk    = '0;
        res.off    = '0;
        hit        = -1;
        free_slot  = -1;
        if (rt == REQ_GET) begin
            for (int s = 0; s < N_SLOTS; s++) begin
                if (hit < 0 && slot_refs[s] != 0 && slot_ino[s] == ino) hit = s;
                if (free_slot < 0 && slot_refs[s] == 0) free_slot = s;
            end
            if (hit >= 0) begin
                res.slot = SLOT_IDX_W'(hit);
                if (slot_refs[hit] == REF_MAX) begin
                    res.status = ST_OVERFLOW;
                    res.refs   = REF_MAX;
                end else begin
                    slot_refs[hit]++;
                    res.status = ST_HIT;
                    res.refs   = slot_refs[hit];
                end
            end else if (free_slot >= 0) begin
                slot_refs[free_slot] = REFS_W'(1);
                slot_ino[free_slot]  = ino;
                res.status           = ST_LOADED;
                res.slot             = SLOT_IDX_W'(free_slot);
                res.refs             = REFS_W'(1);
                {res.blk, res.off}   = record_location(ino);
            end else begin
                res.status = ST_FULL;
            end
        end else if (slot_refs[idx] == 0) begin
            res.status = ST_IDLE;
            res.slot   = idx;
        end else begin
            slot_refs[idx]--;
            res.slot = idx;
            res.refs = slot_refs[idx];
            if (slot_refs[idx] == 0) begin
                res.status         = ST_RELEASED;
                {res.blk, res.off} = record_location(slot_ino[idx]);
            end else begin
                res.status = ST_DECREMENTED;
            end
        end
        return res;
    endfunction

    function automatic int busy_slots();
        int n;
        n = 0;
        for (int s = 0; s < N_SLOTS; s++) if (slot_refs[s] != 0) n++;
        return n;
    endfunction

    // random in-use slot, -1 when the table is empty
    function automatic int pick_busy_slot();
        int start;
        start = $urandom_range(0, N_SLOTS - 1);
        for (int k = 0; k < N_SLOTS; k++)
            if (slot_refs[(start + k) % N_SLOTS] != 0) return (start + k) % N_SLOTS;
        return -1;
    endfunction

    // send one request beat; valid stays high on return so back-to-back beats work
    task automatic send_req(input logic rt, input logic [INODE_W-1:0] ino,
                            input logic [SLOT_IDX_W-1:0] idx);
        int gap;
        gap = tx_idle ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_req_type     <= rt;
        i_inode_number <= ino;
        i_slot_index   <= idx;
        do @(posedge i_clk); while (o_in_stall);
        expected_results.push_back(predict_slot_table(rt, ino, idx));
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // only called with the block idle
    task automatic write_first_block(input logic [BLK_W-1:0] blk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= blk;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        inode_area_base = blk;
    endtask

    task automatic release_all_slots();
        for (int s = 0; s < N_SLOTS; s++)
            while (slot_refs[s] != 0) send_req(REQ_PUT, 16'($urandom), SLOT_IDX_W'(s));
    endtask

    // every status but full and overflow, field extremes, base wrap and a base change between get and put
    task automatic test_directed_ops();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_req(REQ_GET, 16'h0000, 6'h3F);
        send_req(REQ_GET, 16'hFFFF, 6'h00);   // last record of its block
        send_req(REQ_GET, 16'h0000, 6'h15);   // hit
        send_req(REQ_GET, 16'h3039, 6'h2A);
        send_req(REQ_PUT, 16'hFFFF, 6'h00);   // decremented
        send_req(REQ_PUT, 16'h0000, 6'h00);   // released
        send_req(REQ_PUT, 16'h5555, 6'h00);   // put on a free slot
        send_req(REQ_PUT, 16'hAAAA, 6'h3F);   // top slot, free
        send_req(REQ_GET, 16'hFFFF, 6'h3F);   // hit
        send_req(REQ_GET, 16'h0309, 6'h00);   // reuses the lowest free slot
        drain_results();
        write_first_block(16'hFFFF);
        send_req(REQ_GET, 16'h0040, 6'h11);   // block wraps to zero
        send_req(REQ_GET, 16'h003F, 6'h22);   // block 0xFFFF, top offset
        send_req(REQ_PUT, 16'h0000, 6'h01);
        send_req(REQ_PUT, 16'hFFFF, 6'h01);   // writeback address wraps
        drain_results();
        write_first_block(16'h0000);
        // writeback uses the base at release time
        send_req(REQ_PUT, 16'h1234, 6'h02);
        send_req(REQ_PUT, 16'h4321, 6'h00);
        send_req(REQ_PUT, 16'h0F0F, 6'h03);
        send_req(REQ_PUT, 16'hF0F0, 6'h04);
        send_req(REQ_GET, 16'h0001, 6'h3F);
        send_req(REQ_PUT, 16'hFFFF, 6'h00);
        drain_results();
    endtask

    // fill every slot, miss on a full table, then free everything
    task automatic test_table_full();
        int s;
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        release_all_slots();
        for (int k = 0; busy_slots() < N_SLOTS; k++)
            send_req(REQ_GET, 16'(16'hC000 + k * 97), 6'($urandom));
        send_req(REQ_GET, 16'h0005, 6'($urandom));   // full
        send_req(REQ_GET, 16'hC000, 6'($urandom));   // still hits
        s = $urandom_range(0, N_SLOTS - 1);
        while (slot_refs[s] != 0) send_req(REQ_PUT, 16'($urandom), SLOT_IDX_W'(s));
        send_req(REQ_GET, 16'h0005, 6'($urandom));   // takes the freed slot
        send_req(REQ_GET, 16'h0006, 6'($urandom));   // full again
        release_all_slots();
        drain_results();
    endtask

    // drive one count to the maximum and beyond, then back to zero
    task automatic test_count_saturation();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        repeat (int'(REF_MAX) + 2) send_req(REQ_GET, 16'h5A5A, 6'($urandom));
        release_all_slots();
        drain_results();
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_backpressure();
        int s;
        tx_idle      = 1'b0;
        rx_idle      = 1'b0;
        rx_long_hold = 1'b1;
        for (int k = 0; k < 24; k++) begin
            s = pick_busy_slot();
            if (k % 3 == 2 && s >= 0)
                send_req(REQ_PUT, 16'($urandom), SLOT_IDX_W'(s));
            else
                send_req(REQ_GET, 16'(7 + k % 4), 6'($urandom));
        end
        drain_results();
    endtask

    // random gets and puts: mostly hot inodes and in-use slots, plus noise
    task automatic test_random_mix(input int n_items, input int get_pct,
                                   input logic [BLK_W-1:0] area_base,
                                   input bit tx_on, input bit rx_on);
        logic [INODE_W-1:0] pool [16];
        int roll;
        int s;
        drain_results();
        write_first_block(area_base);
        tx_idle = tx_on;
        rx_idle = rx_on;
        foreach (pool[k]) pool[k] = 16'($urandom);
        pool[0] = '0;
        pool[1] = '1;
        repeat (n_items) begin
            roll = $urandom_range(0, 99);
            if (roll < get_pct) begin
                if ($urandom_range(0, 3) != 0)
                    send_req(REQ_GET, pool[$urandom_range(0, 15)], 6'($urandom));
                else
                    send_req(REQ_GET, 16'($urandom), 6'($urandom));
            end else begin
                s = pick_busy_slot();
                if (s < 0 || $urandom_range(0, 9) == 0) s = $urandom_range(0, N_SLOTS - 1);
                send_req(REQ_PUT, 16'($urandom), SLOT_IDX_W'(s));
            end
        end
    endtask

    // result side pacing: random stall per beat, one long hold on request
    initial begin : result_pacing
        int hold;
        i_out_stall = 1'b0;
        @(posedge i_clk);
        forever begin
            if (rx_long_hold) begin
                hold         = LONG_HOLD;
                rx_long_hold = 1'b0;
            end else begin
                hold = rx_idle ? $urandom_range(0, 16) : 0;
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                do @(posedge i_clk); while (!o_out_valid);
                repeat (hold - 1) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // compare each result beat against the oldest expected beat
    always @(posedge i_clk) begin : result_check
        t_slot_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                n_errors++;
                $display("%0t: result beat with none expected, expected none, actual status %0d",
                         $time, o_status);
            end else begin
                want = expected_results.pop_front();
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("result_slot", 32'(want.slot), 32'(o_result_slot));
                check_field("ref_after", 32'(want.refs), 32'(o_ref_after));
                check_field("disk_block", 32'(want.blk), 32'(o_disk_block));
                check_field("byte_offset", 32'(want.off), 32'(o_byte_offset));
            end
        end
    end

    // watchdog: cycles with no beat on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = '0;
        i_in_valid     = 1'b0;
        i_req_type     = REQ_GET;
        i_inode_number = '0;
        i_slot_index   = '0;
        for (int s = 0; s < N_SLOTS; s++) begin
            slot_ino[s]  = '0;
            slot_refs[s] = '0;
        end
        inode_area_base = FIRST_BLK_RST;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_ops();
        test_table_full();
        test_count_saturation();
        test_backpressure();
        test_random_mix(315, 55, 16'($urandom), 1'b1, 1'b1);
        test_random_mix(315, 85, 16'hFFFF, 1'b0, 1'b0);
        test_random_mix(315, 45, 16'h0000, 1'b1, 1'b0);
        test_random_mix(315, 35, FIRST_BLK_RST, 1'b0, 1'b1);
        drain_results();

        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/ihc_pkg.sv
rtl/core/ihc_ctrl.sv
rtl/core/ihc_dp.sv
rtl/core/inode_handle_cache_refcount_core.sv
dv/inode_handle_cache_refcount_core_tb.sv
